// ===== rtl/pett_pkg.sv =====
// ----------------------------------------------------------------------------
// pett_pkg: shared types and constants for the peer endpoint table
// Action codes, the stored entry layout and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pett_pkg;

    // Field widths fixed by the item format
    localparam int IP_W      = 32;
    localparam int PORT_W    = 16;
    localparam int SLOT_W    = 3;
    localparam int TIME_W    = 64;
    localparam int TMO_W     = 63;
    localparam int NODE_W    = 3;
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 8;

    // Timeout after reset: five seconds in nanoseconds
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 63'd5000000000;

    typedef enum logic [1:0] {
        ACT_ARRIVE = 2'd0,
        ACT_CLOSE  = 2'd1,
        ACT_POLL   = 2'd2,
        ACT_ABORT  = 2'd3
    } act_t;

    // One stored peer entry; the live bit is kept apart in flip-flops
    typedef struct packed {
        logic [TIME_W-1:0] last_seen;
        logic [PORT_W-1:0] port;
        logic [IP_W-1:0]   ip;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/peer_endpoint_table_with_timeout.sv =====
// ----------------------------------------------------------------------------
// peer_endpoint_table_with_timeout
// Table of peer endpoints (address, port, last-seen time) with lookup,
// allocation, close by index, aging poll and abort.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  s_axis    in         s_axis_tvalid/tready   tuser: action, tdata: peer item
//  m_axis    out        m_axis_tvalid/tready   tuser: node_found, tdata: node_out
//  cfg       in         cfg_valid/cfg_ready    cfg_data: timeout_ns
//
// Close goes straight from idle to emitting its result; arrive, poll and abort
// first walk through the entry memory, one entry per cycle on its single read
// port. A hit ends the walk early: a match, or an expired entry for poll.
// Reset clears the live bits and loads the five-second timeout; the entry
// memory needs no clearing pass. A result waits in the output register while
// m_axis stalls; the next transaction is accepted once the previous result
// has been loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_endpoint_table_with_timeout
    import pett_pkg::*;
#(
    parameter int NODES = 8
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    // input transactions
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] peer_ip, [47:32] peer_port, [50:48] slot_index, [114:51] now_ns,
    // [119:115] zero
    input  wire [S_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] action
    input  wire [1:0]             s_axis_tuser,
    // result transactions
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    // [2:0] node_out, [7:3] zero
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // [0] node_found
    output logic                  m_axis_tuser,
    // configuration write
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire [TMO_W-1:0]       cfg_data
);

    localparam int IDXW = $clog2(NODES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [IDXW-1:0]   chk_idx_reg, chk_idx_next;
    logic [NODES-1:0]  live_reg, live_next;
    logic [TMO_W-1:0]  timeout_reg;
    logic              pend_found_reg, pend_found_next;
    logic [NODE_W-1:0] pend_node_reg, pend_node_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_found_reg;
    logic [NODE_W-1:0] m_node_reg;

    // latched item
    act_t              act_reg;
    logic [IP_W-1:0]   ip_reg;
    logic [PORT_W-1:0] port_reg;
    logic [TIME_W-1:0] now_reg;

    // entry memory
    entry_t            mem [NODES];
    entry_t            rd_data_reg;
    logic              mem_re;
    logic [IDXW-1:0]   mem_raddr;
    logic              mem_we;
    logic [IDXW-1:0]   mem_waddr;
    entry_t            mem_wdata;

    // input unpacking
    act_t              s_act;
    logic [SLOT_W-1:0] s_slot;
    logic              s_accept;

    // scan decision
    logic              cur_live;
    logic              cur_match;
    logic              cur_expired;
    logic [TIME_W-1:0] cur_age;
    logic              is_poll;
    logic              hit;
    logic              last;
    logic              free_any;
    logic [IDXW-1:0]   free_idx;
    logic              pick_ok;
    logic [IDXW-1:0]   pick_idx;
    logic [IDXW+2:0]   pick_wide;

    assign s_act    = act_t'(s_axis_tuser);
    assign s_slot   = s_axis_tdata[50:48];
    assign s_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_found_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-NODE_W){1'b0}}, m_node_reg};

    // Latch the item on acceptance
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg  <= s_act;
            ip_reg   <= s_axis_tdata[31:0];
            port_reg <= s_axis_tdata[47:32];
            now_reg  <= s_axis_tdata[114:51];
        end
    end

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Lowest free entry
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (!live_reg[i]) begin
                free_any = 1'b1;
                free_idx = IDXW'(i);
            end
        end
    end

    // Evaluate the entry read in the previous cycle
    always_comb begin
        cur_live    = live_reg[chk_idx_reg];
        cur_match   = cur_live && (rd_data_reg.ip == ip_reg)
                      && (rd_data_reg.port == port_reg);
        cur_age     = now_reg - rd_data_reg.last_seen;
        cur_expired = cur_live && (cur_age > {1'b0, timeout_reg});
        is_poll     = (act_reg == ACT_POLL);
        hit         = is_poll ? cur_expired : cur_match;
        last        = (chk_idx_reg == IDXW'(NODES - 1));
        pick_ok     = hit || (!is_poll && free_any);
        pick_idx    = hit ? chk_idx_reg : free_idx;
        pick_wide   = (IDXW+3)'(pick_idx);
    end

    // Control: accept, scan, write back, emit
    always_comb begin
        state_next      = state_reg;
        chk_idx_next    = chk_idx_reg;
        live_next       = live_reg;
        pend_found_next = pend_found_reg;
        pend_node_next  = pend_node_reg;
        m_valid_next    = m_valid_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = pick_idx;
        mem_wdata.ip        = ip_reg;
        mem_wdata.port      = port_reg;
        mem_wdata.last_seen = now_reg;

        // drop the result once taken
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_act == ACT_CLOSE) begin
                        for (int i = 0; i < NODES; i++) begin
                            if (int'(s_slot) == i) begin
                                live_next[i] = 1'b0;
                            end
                        end
                        pend_found_next = 1'b0;
                        pend_node_next  = '0;
                        state_next      = ST_EMIT;
                    end else begin
                        mem_re       = 1'b1;
                        mem_raddr    = '0;
                        chk_idx_next = '0;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit || last) begin
                    pend_found_next = pick_ok;
                    pend_node_next  = pick_ok ? pick_wide[NODE_W-1:0] : '0;
                    if (pick_ok) begin
                        if (is_poll) begin
                            live_next[pick_idx] = 1'b0;
                        end else begin
                            mem_we              = 1'b1;
                            live_next[pick_idx] = (act_reg == ACT_ARRIVE);
                        end
                    end
                    state_next = ST_EMIT;
                end else begin
                    // advance to the next entry
                    mem_re       = 1'b1;
                    mem_raddr    = chk_idx_reg + IDXW'(1);
                    chk_idx_next = chk_idx_reg + IDXW'(1);
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            chk_idx_reg <= '0;
            live_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chk_idx_reg <= chk_idx_next;
            live_reg    <= live_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            timeout_reg <= cfg_data;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        pend_found_reg <= pend_found_next;
        pend_node_reg  <= pend_node_next;
        if (state_reg == ST_EMIT && (!m_valid_reg || m_axis_tready)) begin
            m_found_reg <= pend_found_reg;
            m_node_reg  <= pend_node_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_axis_tready)
        else $error("transaction accepted while an item was in progress");

    a_emit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) && m_valid_reg && !m_axis_tready
        |=> (state_reg == ST_EMIT))
        else $error("pending result left before output register was free");

    a_close_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) && (act_reg == ACT_CLOSE) |-> !pend_found_reg)
        else $error("close produced a found result");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (int'(chk_idx_reg) < NODES))
        else $error("scan index beyond table");

endmodule

`default_nettype wire

// ===== tb/tb_peer_endpoint_table_with_timeout.sv =====
// ----------------------------------------------------------------------------
// tb_peer_endpoint_table_with_timeout
// Self-checking bench for the peer endpoint table. A directed sequence covers
// refresh, allocation, full table, close, aging at and past the timeout,
// clock wrap and abort. Random traffic then runs over a small endpoint pool
// under several timeout settings and idle patterns. Each result is compared
// with a behavioural copy of the table, or a directed row's fixed result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_peer_endpoint_table_with_timeout;
    import pett_pkg::*;

    localparam int NODES       = 8;
    localparam int POOL_N      = 10;
    localparam int PHASE_ITEMS = 117;
    localparam int N_PHASES    = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [TIME_W-1:0] T_MAX = '1;

    typedef struct {
        act_t              action;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] now_ns;
    } peer_item_t;

    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] node;
    } node_result_t;

    typedef struct {
        peer_item_t   item;
        bit           typed;
        node_result_t res;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [1:0]           s_axis_tuser = ACT_ARRIVE;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [TMO_W-1:0]     cfg_data = '0;

    // Shadow table and timeout register
    logic              slot_live [NODES];
    logic [IP_W-1:0]   slot_ip   [NODES];
    logic [PORT_W-1:0] slot_port [NODES];
    logic [TIME_W-1:0] slot_seen [NODES];
    logic [TMO_W-1:0]  tmo_model;

    node_result_t      node_result_q[$];
    node_result_t      want;
    dir_row_t          dir_rows[$];
    logic [IP_W-1:0]   pool_ip   [POOL_N];
    logic [PORT_W-1:0] pool_port [POOL_N];
    logic [TIME_W-1:0] now_cur;
    logic [TMO_W-1:0]  phase_tmo [N_PHASES];

    int sender_idle_pct = 0;
    int rcv_stall_pct   = 0;
    int fail_count      = 0;
    int found_count     = 0;
    int cycle_count     = 0;
    int act_count [4];

    peer_endpoint_table_with_timeout #(
        .NODES(NODES)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Apply one action to the shadow table and return the node it reports
    function automatic node_result_t apply_peer_action(input peer_item_t it);
        node_result_t      res;
        int                pick;
        bit                hit;
        logic [TIME_W-1:0] age;
        res  = '0;
        pick = -1;
        hit  = 1'b0;
        case (it.action)
            ACT_ARRIVE, ACT_ABORT: begin
                // a live match beats any free slot, else take the lowest free
                for (int i = 0; i < NODES; i++) begin
                    if (slot_live[i] && slot_ip[i] == it.ip && slot_port[i] == it.port) begin
                        if (!hit) begin
                            pick = i;
                            hit  = 1'b1;
                        end
                    end else if (!slot_live[i] && pick < 0) begin
                        pick = i;
                    end
                end
                if (pick >= 0) begin
                    slot_ip[pick]   = it.ip;
                    slot_port[pick] = it.port;
                    slot_seen[pick] = it.now_ns;
                    slot_live[pick] = (it.action == ACT_ARRIVE);
                end
            end
            ACT_CLOSE: begin
                slot_live[it.slot] = 1'b0;
            end
            ACT_POLL: begin
                // age wraps modulo 2^64; strictly greater than the timeout
                for (int i = 0; i < NODES; i++) begin
                    age = it.now_ns - slot_seen[i];
                    if (pick < 0 && slot_live[i] && age > {1'b0, tmo_model}) begin
                        slot_live[i] = 1'b0;
                        pick = i;
                    end
                end
            end
            default: ;
        endcase
        if (pick >= 0) begin
            res.found = 1'b1;
            res.node  = pick[NODE_W-1:0];
        end
        return res;
    endfunction

    function automatic dir_row_t mk_row(input act_t a, input logic [IP_W-1:0] ip,
                                        input logic [PORT_W-1:0] port,
                                        input logic [SLOT_W-1:0] slot,
                                        input logic [TIME_W-1:0] now_ns, input bit typed,
                                        input logic found, input logic [NODE_W-1:0] node);
        dir_row_t r;
        r.item.action = a;
        r.item.ip     = ip;
        r.item.port   = port;
        r.item.slot   = slot;
        r.item.now_ns = now_ns;
        r.typed       = typed;
        r.res.found   = found;
        r.res.node    = node;
        return r;
    endfunction

    // Mostly pool endpoints so that hits and full tables occur; time mostly advances
    function automatic peer_item_t random_peer_item();
        peer_item_t        it;
        int                k;
        int                r;
        logic [TIME_W-1:0] rnd;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            it.action = ACT_ARRIVE;
        end else if (r < 60) begin
            it.action = ACT_CLOSE;
        end else if (r < 85) begin
            it.action = ACT_POLL;
        end else begin
            it.action = ACT_ABORT;
        end
        k       = $urandom_range(0, POOL_N - 1);
        it.ip   = pool_ip[k];
        it.port = pool_port[k];
        if ($urandom_range(0, 99) < 15) begin
            it.ip = $urandom;
        end
        if ($urandom_range(0, 99) < 15) begin
            it.port = PORT_W'($urandom_range(0, 65535));
        end
        it.slot = SLOT_W'($urandom_range(0, NODES - 1));
        rnd = {$urandom, $urandom};
        r   = $urandom_range(0, 99);
        if (r < 8) begin
            now_cur = rnd;
        end else if (r >= 20) begin
            now_cur = now_cur + (rnd >> $urandom_range(0, 63));
        end
        it.now_ns = now_cur;
        return it;
    endfunction

    // Present one item, hold until taken, then record the expected node
    task automatic send_item(input peer_item_t it, input bit typed,
                             input node_result_t typed_res);
        int           gap;
        node_result_t res;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.action;
        s_axis_tdata  <= {5'b0, it.now_ns, it.slot, it.port, it.ip};
        do @(posedge aclk); while (!s_axis_tready);
        res = apply_peer_action(it);
        node_result_q.push_back(typed ? typed_res : res);
        act_count[it.action]++;
    endtask

    // Drain, let the block settle, then write the timeout
    task automatic write_timeout(input logic [TMO_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (node_result_q.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tmo_model = value;
    endtask

    // Check result transactions and stall the result channel
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (node_result_q.size() == 0) begin
                $error("unexpected result: node_found %0d node_out %0d",
                       m_axis_tuser, m_axis_tdata[NODE_W-1:0]);
                fail_count++;
            end else begin
                want = node_result_q.pop_front();
                if (m_axis_tuser !== want.found) begin
                    $error("node_found: expected %0d, got %0d", want.found, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[NODE_W-1:0] !== want.node) begin
                    $error("node_out: expected %0d, got %0d", want.node,
                           m_axis_tdata[NODE_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tuser === 1'b1) begin
                    found_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     node_result_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        tmo_model = TIMEOUT_RESET;
        now_cur   = '0;
        for (int i = 0; i < NODES; i++) begin
            slot_live[i] = 1'b0;
            slot_ip[i]   = '0;
            slot_port[i] = '0;
            slot_seen[i] = '0;
        end
        for (int i = 0; i < 4; i++) begin
            act_count[i] = 0;
        end

        // Directed sequence, timeout at its reset value
        dir_rows.push_back(mk_row(ACT_POLL,   32'h0, 16'h0, 3'd0, T_MAX, 1, 1'b0, 3'd0));
        dir_rows.push_back(mk_row(ACT_ARRIVE, 32'h0, 16'h0, 3'd0, 64'd0, 1, 1'b1, 3'd0));
        dir_rows.push_back(mk_row(ACT_ARRIVE, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, T_MAX,
                                  1, 1'b1, 3'd1));
        // refresh an existing entry
        dir_rows.push_back(mk_row(ACT_ARRIVE, 32'h0, 16'h0, 3'd0, 64'd7, 1, 1'b1, 3'd0));
        dir_rows.push_back(mk_row(ACT_CLOSE,  32'h0, 16'h0, 3'd0, 64'd0, 1, 1'b0, 3'd0));
        // live match wins over a lower free slot
        dir_rows.push_back(mk_row(ACT_ARRIVE, 32'hFFFF_FFFF, 16'hFFFF, 3'd0, 64'd3,
                                  1, 1'b1, 3'd1));
        // abort on a free slot, then on a live match
        dir_rows.push_back(mk_row(ACT_ABORT,  32'h0A00_0001, 16'd80, 3'd0, 64'd9,
                                  1, 1'b1, 3'd0));
        dir_rows.push_back(mk_row(ACT_ABORT,  32'hFFFF_FFFF, 16'hFFFF, 3'd0, 64'd10,
                                  1, 1'b1, 3'd1));
        dir_rows.push_back(mk_row(ACT_POLL,   32'h0, 16'h0, 3'd0, 64'd9000000000,
                                  1, 1'b0, 3'd0));
        dir_rows.push_back(mk_row(ACT_ARRIVE, 32'hC0A8_0001, 16'd1000, 3'd0, 64'd100,
                                  0, 1'b0, 3'd0));
        dir_rows.push_back(mk_row(ACT_ARRIVE, 32'hC0A8_0001, 16'd1001, 3'd0, 64'd200,
                                  0, 1'b0, 3'd0));
        dir_rows.push_back(mk_row(ACT_ARRIVE, 32'hC0A8_0002, 16'd1000, 3'd0, 64'd300,
                                  0, 1'b0, 3'd0));
        // age equal to the timeout is not yet expired; one more is
        dir_rows.push_back(mk_row(ACT_POLL,   32'h0, 16'h0, 3'd0, 64'd5000000100,
                                  1, 1'b0, 3'd0));
        dir_rows.push_back(mk_row(ACT_POLL,   32'h0, 16'h0, 3'd0, 64'd5000000101,
                                  1, 1'b1, 3'd0));
        // clock wrapped below the stored times
        dir_rows.push_back(mk_row(ACT_POLL,   32'h0, 16'h0, 3'd0, 64'd0, 0, 1'b0, 3'd0));
        dir_rows.push_back(mk_row(ACT_ARRIVE, 32'h1, 16'h1, 3'd0, 64'hFFFF_FFFF_FFFF_FFF0,
                                  0, 1'b0, 3'd0));
        dir_rows.push_back(mk_row(ACT_POLL,   32'h0, 16'h0, 3'd0, 64'd5, 0, 1'b0, 3'd0));
        // fill the remaining slots
        for (int i = 1; i < NODES; i++) begin
            dir_rows.push_back(mk_row(ACT_ARRIVE, IP_W'(32'h0A0A_0000 + i),
                                      PORT_W'(5000 + i), 3'd0,
                                      64'd1000, 0, 1'b0, 3'd0));
        end
        // full table
        dir_rows.push_back(mk_row(ACT_ARRIVE, 32'h5555_AAAA, 16'h5A5A, 3'd0, 64'd1001,
                                  1, 1'b0, 3'd0));
        dir_rows.push_back(mk_row(ACT_ABORT,  32'hAAAA_5555, 16'hA5A5, 3'd0, 64'd1002,
                                  1, 1'b0, 3'd0));
        dir_rows.push_back(mk_row(ACT_CLOSE,  32'h0, 16'h0, 3'd7, 64'd0, 1, 1'b0, 3'd0));

        // Hold reset, then release it
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r]) begin
            send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].res);
        end

        // Random phases: one timeout setting and one idle pattern each
        phase_tmo[0] = '0;
        phase_tmo[1] = '1;
        phase_tmo[2] = 63'd1000;
        phase_tmo[3] = 63'({$urandom, $urandom} >> $urandom_range(1, 40));
        phase_tmo[4] = TIMEOUT_RESET;
        phase_tmo[5] = 63'd1;
        for (int p = 0; p < N_PHASES; p++) begin
            write_timeout(phase_tmo[p]);
            case (p % 4)
                0: begin
                    sender_idle_pct = 0;
                    rcv_stall_pct   = 0;
                end
                1: begin
                    sender_idle_pct = 84;
                    rcv_stall_pct   = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    rcv_stall_pct   = 84;
                end
                default: begin
                    sender_idle_pct = 23;
                    rcv_stall_pct   = 23;
                end
            endcase
            // fresh endpoint pool, extremes and shared addresses included
            for (int k = 0; k < POOL_N; k++) begin
                pool_ip[k]   = (k > 2 && k % 3 == 0) ? pool_ip[k-1] : $urandom;
                pool_port[k] = PORT_W'($urandom_range(0, 65535));
            end
            pool_ip[0]   = '0;
            pool_port[0] = '0;
            pool_ip[1]   = '1;
            pool_port[1] = '1;
            repeat (PHASE_ITEMS) begin
                send_item(random_peer_item(), 1'b0, '0);
            end
        end

        // Drain and settle
        s_axis_tvalid <= 1'b0;
        while (node_result_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Actions sent: %0d arrive, %0d close, %0d poll, %0d abort",
                 act_count[ACT_ARRIVE], act_count[ACT_CLOSE], act_count[ACT_POLL],
                 act_count[ACT_ABORT]);
        $display("%0d results named a slot; timeout swept over %0d values from zero to max",
                 found_count, N_PHASES);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== peer_endpoint_table_with_timeout.f =====
rtl/pett_pkg.sv
rtl/peer_endpoint_table_with_timeout.sv
tb/tb_peer_endpoint_table_with_timeout.sv
